@@ rtl/core/cfd_pkg.sv @@
// ----------------------------------------------------------------------------
// cfd_pkg
// Types and constants shared by the checksummed frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

  localparam int ByteW     = 8;
  localparam int WordW     = 16;
  localparam int NumWords  = 7;
  localparam int PosW      = 5;
  localparam int WordIdxW  = 3;
  localparam int CfgIndexW = 1;
  localparam int CfgDataW  = 8;

  localparam logic [PosW-1:0] PosStart       = 5'd0;
  localparam logic [PosW-1:0] PosPayloadLast = 5'd14;
  localparam logic [PosW-1:0] PosChecksum    = 5'd15;
  localparam logic [PosW-1:0] PosEnd         = 5'd16;
  localparam logic [PosW-1:0] PosSaturate    = 5'd18;

  localparam logic [ByteW-1:0] StartMarkerReset = 8'hAA;
  localparam logic [ByteW-1:0] EndMarkerReset   = 8'hBB;

  typedef enum logic [CfgIndexW-1:0] {
    REG_START_MARKER = 1'b0,
    REG_END_MARKER   = 1'b1
  } cfd_reg_t;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] end_marker;
  } cfd_cfg_t;

  typedef struct packed {
    logic [WordW-1:0] shoulder_angle;
    logic [WordW-1:0] elbow_angle;
    logic [WordW-1:0] wrist_angle;
    logic [WordW-1:0] grip_force;
    logic [WordW-1:0] shoulder_drive;
    logic [WordW-1:0] elbow_drive;
    logic [WordW-1:0] wrist_drive;
  } cfd_result_t;

  typedef struct packed {
    logic        valid;
    cfd_result_t result;
  } cfd_push_t;

endpackage

`default_nettype wire

@@ rtl/core/cfd_if.sv @@
// ----------------------------------------------------------------------------
// cfd_if
// Valid/ready channels for packet bytes in and decoded frames out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfd_byte_if
  import cfd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             packet_end;

  modport source (output valid, output data_byte, output packet_end, input ready);
  modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

interface cfd_frame_if
  import cfd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] shoulder_angle;
  logic [WordW-1:0] elbow_angle;
  logic [WordW-1:0] wrist_angle;
  logic [WordW-1:0] grip_force;
  logic [WordW-1:0] shoulder_drive;
  logic [WordW-1:0] elbow_drive;
  logic [WordW-1:0] wrist_drive;

  modport source (
    output valid, output shoulder_angle, output elbow_angle, output wrist_angle,
    output grip_force, output shoulder_drive, output elbow_drive, output wrist_drive,
    input ready
  );
  modport sink (
    input valid, input shoulder_angle, input elbow_angle, input wrist_angle,
    input grip_force, input shoulder_drive, input elbow_drive, input wrist_drive,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/checksummed_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// checksummed_frame_deframer
// Fixed-length frame deframer with additive checksum.
// ----------------------------------------------------------------------------
// rx carries one packet byte per transaction, with packet_end on the last
// byte. A packet is 17 bytes: start marker, 14 payload bytes forming seven
// little-endian words, a modulo-256 sum of the payload, and the end marker.
// A good packet yields one transaction on tx with the seven words; any bad
// or mis-sized packet is dropped without trace.
// rx takes one byte per cycle while rx.ready is high. The result of a good
// packet is registered at the edge that accepts its last byte and is shown on
// tx in the next cycle unless tx is stalled. Throughput is set by the per-byte
// add and compare between the packet state registers and the result register.
// A stalled tx holds its transaction; a skid slot lets rx keep taking bytes,
// and rx.ready falls only while both the output register and the skid slot
// are full.
// Reset clears the packet state and both result slots and loads the marker
// registers with 0xAA and 0xBB. Marker writes take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module checksummed_frame_deframer
  import cfd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  cfd_byte_if.sink                  rx,
  cfd_frame_if.source               tx,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);

  cfd_cfg_t    cfg;
  cfd_push_t   push;
  cfd_result_t result;
  logic        fire;
  logic        in_ready;

  assign rx.ready = in_ready;
  assign fire     = rx.valid && in_ready;

  cfd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cfd_frame_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .data_byte  (rx.data_byte),
    .packet_end (rx.packet_end),
    .cfg        (cfg),
    .push       (push)
  );

  cfd_result_buffer u_buffer (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .out_ready  (tx.ready),
    .out_valid  (tx.valid),
    .out_result (result),
    .in_ready   (in_ready)
  );

  assign tx.shoulder_angle = result.shoulder_angle;
  assign tx.elbow_angle    = result.elbow_angle;
  assign tx.wrist_angle    = result.wrist_angle;
  assign tx.grip_force     = result.grip_force;
  assign tx.shoulder_drive = result.shoulder_drive;
  assign tx.elbow_drive    = result.elbow_drive;
  assign tx.wrist_drive    = result.wrist_drive;

endmodule

`default_nettype wire

@@ rtl/core/cfd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// cfd_cfg_regs
// Start and end marker registers behind the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_cfg_regs
  import cfd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  output cfd_cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= StartMarkerReset;
      cfg.end_marker   <= EndMarkerReset;
    end else if (cfg_we) begin
      unique case (cfd_reg_t'(cfg_index))
        REG_START_MARKER: cfg.start_marker <= cfg_data[ByteW-1:0];
        REG_END_MARKER:   cfg.end_marker   <= cfg_data[ByteW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cfd_frame_parser.sv @@
// ----------------------------------------------------------------------------
// cfd_frame_parser
// Byte position tracking, checksum, marker checks and word assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_frame_parser
  import cfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic [ByteW-1:0] data_byte,
  input  wire logic             packet_end,
  input  wire cfd_cfg_t         cfg,
  output cfd_push_t             push
);

  logic [PosW-1:0]     pos;
  logic [ByteW-1:0]    running_sum;
  logic                start_seen;
  logic                sum_matches;
  logic [WordW-1:0]    payload_words [NumWords];

  logic [PosW-1:0]     pos_m1;
  logic [WordIdxW-1:0] word_idx;
  logic                in_payload;

  assign pos_m1     = pos - PosW'(1);
  assign word_idx   = pos_m1[WordIdxW:1];
  assign in_payload = (pos != PosStart) && (pos <= PosPayloadLast);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= PosStart;
      running_sum <= '0;
      start_seen  <= 1'b0;
      sum_matches <= 1'b0;
    end else if (fire) begin
      if (pos == PosStart) begin
        start_seen <= (data_byte == cfg.start_marker);
      end else if (in_payload) begin
        running_sum <= running_sum + data_byte;
      end else if (pos == PosChecksum) begin
        sum_matches <= (data_byte == running_sum);
      end
      // drop packet state on every last byte
      if (packet_end) begin
        pos         <= PosStart;
        running_sum <= '0;
        start_seen  <= 1'b0;
        sum_matches <= 1'b0;
      end else if (pos < PosSaturate) begin
        pos <= pos + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NumWords; i++) begin
      if (fire && in_payload && (word_idx == WordIdxW'(i))) begin
        if (pos[0]) begin
          payload_words[i][ByteW-1:0] <= data_byte;
        end else begin
          payload_words[i][WordW-1:ByteW] <= data_byte;
        end
      end
    end
  end

  always_comb begin
    push.valid = fire && packet_end && (pos == PosEnd) && start_seen && sum_matches &&
                 (data_byte == cfg.end_marker);
    push.result.shoulder_angle = payload_words[0];
    push.result.elbow_angle    = payload_words[1];
    push.result.wrist_angle    = payload_words[2];
    push.result.grip_force     = payload_words[3];
    push.result.shoulder_drive = payload_words[4];
    push.result.elbow_drive    = payload_words[5];
    push.result.wrist_drive    = payload_words[6];
  end

endmodule

`default_nettype wire

@@ rtl/core/cfd_result_buffer.sv @@
// ----------------------------------------------------------------------------
// cfd_result_buffer
// Output register with a skid slot so input keeps flowing under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_result_buffer
  import cfd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfd_push_t push,
  input  wire logic  out_ready,
  output logic       out_valid,
  output cfd_result_t out_result,
  output logic       in_ready
);

  logic        main_valid;
  logic        skid_valid;
  cfd_result_t main_result;
  cfd_result_t skid_result;
  logic        pop;

  assign pop        = main_valid && out_ready;
  assign out_valid  = main_valid;
  assign out_result = main_result;
  assign in_ready   = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_result <= skid_result;
        skid_valid  <= 1'b0;
      end else if (push.valid) begin
        main_result <= push.result;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push.valid) begin
      if (!main_valid) begin
        main_result <= push.result;
        main_valid  <= 1'b1;
      end else begin
        skid_result <= push.result;
        skid_valid  <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cfd_checker.sv @@
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_checker
  import cfd_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             rx_valid,
  input wire logic             rx_ready,
  input wire logic             rx_packet_end,
  input wire logic             tx_valid,
  input wire logic             tx_ready,
  input wire logic [WordW-1:0] tx_shoulder_angle,
  input wire logic [WordW-1:0] tx_wrist_drive
);

  // no transaction offered straight after reset
  assert property (@(posedge clk) rst |=> !tx_valid)
    else $error("tx valid after reset");

  // stalled transaction holds
  assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(tx_shoulder_angle) &&
                              $stable(tx_wrist_drive))
    else $error("stalled tx transaction changed");

  // a new result follows the last byte of a packet
  assert property (@(posedge clk) disable iff (rst)
    $rose(tx_valid) |-> $past(rx_valid && rx_ready && rx_packet_end))
    else $error("tx result without a packet end");

  // rx stalls only while a result waits on tx
  assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> tx_valid)
    else $error("rx stalled with tx empty");

endmodule

bind checksummed_frame_deframer cfd_checker u_cfd_checker (
  .clk               (clk),
  .rst               (rst),
  .rx_valid          (rx.valid),
  .rx_ready          (rx.ready),
  .rx_packet_end     (rx.packet_end),
  .tx_valid          (tx.valid),
  .tx_ready          (tx.ready),
  .tx_shoulder_angle (tx.shoulder_angle),
  .tx_wrist_drive    (tx.wrist_drive)
);

`default_nettype wire
